// ----- hw/rtl/icb_pkg.sv -----
// ----------------------------------------------------------------------------
// icb_pkg
// Shared types and constants of the inverse colormap builder.
// ----------------------------------------------------------------------------
package icb_pkg;

    localparam int CMD_W   = 2;
    localparam int COLOR_W = 8;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 3;
    localparam int DIST_W  = 18;
    localparam int WORK_W  = 24;   // signed working width of distances and increments
    localparam int DIFF_W  = 10;   // signed offset of a color from its cell center
    localparam int PREC_MIN = 4;
    localparam int PREC_SPECIAL = 5;

    localparam logic [CFG_W-1:0]  PREC_RESET = 3'd5;
    localparam logic [DIST_W-1:0] DIST_MAX   = 18'h3FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

endpackage

// ----- hw/rtl/icb_if.sv -----
// ----------------------------------------------------------------------------
// icb_if
// Valid/ready channels of the inverse colormap builder: command words in,
// result words out.
// ----------------------------------------------------------------------------
interface icb_in_if
    import icb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output command, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input command, input red, input green, input blue,
                    output ready);
endinterface

interface icb_out_if
    import icb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] palette_index;
    logic             index_valid;
    logic             done_res;

    modport source (output valid, output palette_index, output index_valid, output done_res,
                    input ready);
    modport sink   (input valid, input palette_index, input index_valid, input done_res,
                    output ready);
endinterface

// ----- hw/rtl/inverse_colormap_builder_top.sv -----
// ----------------------------------------------------------------------------
// inverse_colormap_builder_top
// Builds a quantized RGB-cube to palette-index map one palette color at a
// time and answers lookups from it.
// ----------------------------------------------------------------------------
// One command word is worked at a time; ready is low while it runs. After
// reset and for every start command a clearing pass writes the whole cube
// memory, one entry per cycle, during which no word is accepted. An add
// walks outward from the color's own cell; each visited cell takes a memory
// read, then a compare and claim-write through the single read/write port
// pair, with loop overhead per row and plane and setup before the walk.
// A result waits in an output register, and the next word can be accepted
// meanwhile.
// ----------------------------------------------------------------------------
module inverse_colormap_builder_top
    import icb_pkg::*;
#(
    parameter int MAX_BITS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    icb_in_if.sink           i_in,
    icb_out_if.source        o_out
);

    localparam int ADDR_W = 3 * MAX_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CW     = MAX_BITS + 2;
    localparam int BW     = $clog2(MAX_BITS + 1);
    localparam int MEM_W  = DIST_W + IDX_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_SQ,
        S_R_INIT, S_R_TEST, S_R_POST, S_R_INIT_DN,
        S_G_START, S_G_TEST, S_G_POST, S_G_INIT_DN,
        S_B_START, S_B_TEST, S_B_CMP, S_B_INIT_DN,
        S_LOOK, S_LOOK_RD, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        BP_UP_SEEK, BP_UP_FILL, BP_DN_SEEK, BP_DN_FILL
    } t_bphase;

    typedef struct packed {
        logic signed [CW-1:0]     c;
        logic signed [DIFF_W-1:0] d;
        logic signed [WORK_W-1:0] inc;
    } t_axis;

    // per-channel cell, center offset and first increment
    function automatic t_axis f_axis(input logic [COLOR_W-1:0] v, input logic [BW-1:0] bits);
        t_axis a;
        logic [3:0] sh;
        logic signed [WORK_W-1:0] sv, sc, s6;
        sh = 4'(8 - int'(bits));
        sv = WORK_W'(v);
        s6 = WORK_W'(v >> 2);
        if (bits == BW'(PREC_SPECIAL)) begin
            sc    = WORK_W'(v >> 3);
            a.d   = DIFF_W'(s6 - (2 * sc + 1));
            a.inc = WORK_W'(4 - 4 * s6 + 8 * sc);
        end else begin
            sc    = WORK_W'(v >> sh);
            a.d   = DIFF_W'(sv - (sc << sh) - ((WORK_W'(1) << sh) >> 1));
            a.inc = WORK_W'(2 * ((sc + 1) << (2 * sh)) - 2 * (sv << sh));
        end
        a.c = CW'(sc);
        return a;
    endfunction

    // cube memory: {distance, index}
    logic [MEM_W-1:0] mem [DEPTH];
    logic [MEM_W-1:0] r_rd_data;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [CFG_W-1:0]     r_prec;
    logic [BW-1:0]        r_bits;
    logic [COLOR_W-1:0]   r_red, r_green, r_blue;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_map_valid;
    logic [ADDR_W-1:0]    r_clr;
    logic                 r_clr_reply;

    logic signed [CW-1:0]     r_rc, r_gc, r_bc, r_lim;
    logic signed [DIFF_W-1:0] r_dr, r_dg, r_db;
    logic signed [WORK_W-1:0] r_inc_r, r_inc_g, r_inc_b, r_tstep, r_cdist;
    logic [ADDR_W-1:0]        r_cpos, r_gstr, r_rstr;
    logic [1:0]               r_sq_sel;

    logic signed [CW-1:0]     r_r, r_g, r_b, r_g_here, r_b_here;
    logic signed [WORK_W-1:0] r_rx, r_rdist, r_gx, r_gdist, r_kd, r_g_inc;
    logic signed [WORK_W-1:0] r_bx, r_bd, r_b_inc;
    logic [ADDR_W-1:0]        r_rpos, r_gpos, r_kp, r_p;
    logic                     r_rup, r_rhit, r_gfirst, r_gup, r_ghit, r_bfirst, r_bhit;
    t_bphase                  r_bph;

    logic [IDX_W-1:0] r_res_idx, r_o_idx;
    logic             r_res_iv, r_o_iv, r_o_valid;

    // combinational helpers
    logic [BW-1:0]            w_eff;
    t_axis                    w_ax_r, w_ax_g, w_ax_b;
    logic [3:0]               w_sh;
    logic [ADDR_W-1:0]        w_look_addr, w_rd_addr, w_wr_addr;
    logic [MEM_W-1:0]         w_wr_data;
    logic                     w_we, w_closer, w_bup, w_b_inb, w_g_inb, w_r_inb;
    logic signed [DIFF_W-1:0] w_dsel;
    logic signed [2*DIFF_W-1:0] w_sq;
    logic signed [WORK_W-1:0] w_bh_inc, w_gh_inc;
    logic signed [CW-1:0]     w_bh, w_gh;

    always_comb begin
        if (int'(r_prec) < PREC_MIN) begin
            w_eff = BW'(PREC_MIN);
        end else if (int'(r_prec) > MAX_BITS) begin
            w_eff = BW'(MAX_BITS);
        end else begin
            w_eff = BW'(r_prec);
        end
    end

    assign w_ax_r = f_axis(r_red, r_bits);
    assign w_ax_g = f_axis(r_green, r_bits);
    assign w_ax_b = f_axis(r_blue, r_bits);
    assign w_sh   = 4'(8 - int'(r_bits));

    assign w_look_addr = (ADDR_W'(r_red >> w_sh) << (2 * r_bits))
                       | (ADDR_W'(r_green >> w_sh) << r_bits)
                       | ADDR_W'(r_blue >> w_sh);

    always_comb begin
        case (r_sq_sel)
            2'd0:    w_dsel = r_dr;
            2'd1:    w_dsel = r_dg;
            default: w_dsel = r_db;
        endcase
    end
    assign w_sq = w_dsel * w_dsel;

    // the stored distance must exceed the candidate; a negative candidate never wins
    assign w_closer = !r_bd[WORK_W-1] && (r_bd[WORK_W-2:DIST_W] == '0)
                    && (r_rd_data[MEM_W-1:IDX_W] > r_bd[DIST_W-1:0]);

    assign w_bup   = (r_bph == BP_UP_SEEK) || (r_bph == BP_UP_FILL);
    assign w_b_inb = w_bup ? (r_b <= r_lim) : !r_b[CW-1];
    assign w_g_inb = r_gup ? (r_g <= r_lim) : !r_g[CW-1];
    assign w_r_inb = r_rup ? (r_r <= r_lim) : !r_r[CW-1];

    assign w_bh     = r_bfirst ? r_bc : r_b_here;
    assign w_bh_inc = r_bfirst ? r_inc_b : r_b_inc;
    assign w_gh     = r_gfirst ? r_gc : r_g_here;
    assign w_gh_inc = r_gfirst ? r_inc_g : r_g_inc;

    assign w_rd_addr = (r_state == S_LOOK) ? w_look_addr : r_p;
    assign w_we      = (r_state == S_CLEAR) || ((r_state == S_B_CMP) && w_closer);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr : r_p;
    assign w_wr_data = (r_state == S_CLEAR) ? {DIST_MAX, IDX_W'(0)}
                                            : {r_bd[DIST_W-1:0], r_cnt[IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.palette_index = r_o_idx;
    assign o_out.index_valid   = r_o_iv;
    assign o_out.done_res      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_prec      <= PREC_RESET;
            r_cnt       <= '0;
            r_map_valid <= 1'b0;
            r_clr       <= '0;
            r_clr_reply <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prec <= i_cfg_data;
            end
            // in S_DONE the output register is reloaded below
            if (o_out.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == '1) begin
                        r_state <= r_clr_reply ? S_DONE : S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd     <= t_cmd'(i_in.command);
                        r_red     <= i_in.red;
                        r_green   <= i_in.green;
                        r_blue    <= i_in.blue;
                        r_bits    <= w_eff;
                        r_res_idx <= '0;
                        r_res_iv  <= 1'b0;
                        case (t_cmd'(i_in.command))
                            CMD_START: begin
                                r_cnt       <= '0;
                                r_map_valid <= 1'b0;
                                r_clr       <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            CMD_ADD:    r_state <= S_SETUP;
                            CMD_LOOKUP: r_state <= r_map_valid ? S_LOOK : S_DONE;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end

                S_SETUP: begin
                    r_rc    <= w_ax_r.c;
                    r_gc    <= w_ax_g.c;
                    r_bc    <= w_ax_b.c;
                    r_dr    <= w_ax_r.d;
                    r_dg    <= w_ax_g.d;
                    r_db    <= w_ax_b.d;
                    r_inc_r <= w_ax_r.inc;
                    r_inc_g <= w_ax_g.inc;
                    r_inc_b <= w_ax_b.inc;
                    r_tstep <= (r_bits == BW'(PREC_SPECIAL)) ? WORK_W'(8)
                                                             : WORK_W'(2) << (2 * w_sh);
                    r_cpos  <= (ADDR_W'($unsigned(w_ax_r.c)) << (2 * r_bits))
                             | (ADDR_W'($unsigned(w_ax_g.c)) << r_bits)
                             | ADDR_W'($unsigned(w_ax_b.c));
                    r_lim   <= (CW'(1) << r_bits) - CW'(1);
                    r_gstr  <= ADDR_W'(1) << r_bits;
                    r_rstr  <= ADDR_W'(1) << (2 * r_bits);
                    r_cdist <= '0;
                    r_sq_sel <= '0;
                    r_state <= S_SQ;
                end

                S_SQ: begin
                    r_cdist  <= r_cdist + WORK_W'(w_sq);
                    r_sq_sel <= r_sq_sel + 2'd1;
                    if (r_sq_sel == 2'd2) begin
                        r_state <= S_R_INIT;
                    end
                end

                // ---- red planes ----
                S_R_INIT: begin
                    r_r      <= r_rc;
                    r_rdist  <= r_cdist;
                    r_rx     <= r_inc_r;
                    r_rpos   <= r_cpos;
                    r_gfirst <= 1'b1;
                    r_rhit   <= 1'b0;
                    r_rup    <= 1'b1;
                    r_state  <= S_R_TEST;
                end

                S_R_TEST: begin
                    if (w_r_inb) begin
                        r_state <= S_G_START;
                    end else begin
                        r_state <= r_rup ? S_R_INIT_DN : S_DONE;
                    end
                end

                S_R_POST: begin
                    if (!r_ghit && r_rhit) begin
                        r_state <= r_rup ? S_R_INIT_DN : S_DONE;
                    end else begin
                        if (r_ghit) begin
                            r_rhit <= 1'b1;
                        end
                        r_gfirst <= 1'b0;
                        if (r_rup) begin
                            r_r     <= r_r + CW'(1);
                            r_rpos  <= r_rpos + r_rstr;
                            r_rdist <= r_rdist + r_rx;
                            r_rx    <= r_rx + r_tstep;
                        end else begin
                            r_r     <= r_r - CW'(1);
                            r_rpos  <= r_rpos - r_rstr;
                            r_rx    <= r_rx - r_tstep;
                            r_rdist <= r_rdist - (r_rx - r_tstep);
                        end
                        r_state <= S_R_TEST;
                    end
                end

                S_R_INIT_DN: begin
                    r_r      <= r_rc - CW'(1);
                    r_rx     <= r_inc_r - r_tstep;
                    r_rdist  <= r_cdist - (r_inc_r - r_tstep);
                    r_rpos   <= r_cpos - r_rstr;
                    r_gfirst <= 1'b1;
                    r_rup    <= 1'b0;
                    r_state  <= S_R_TEST;
                end

                // ---- green rows ----
                S_G_START: begin
                    r_g_here <= w_gh;
                    r_g_inc  <= w_gh_inc;
                    r_g      <= w_gh;
                    r_gx     <= w_gh_inc;
                    r_kd     <= r_rdist;
                    r_gdist  <= r_rdist;
                    r_kp     <= r_rpos;
                    r_gpos   <= r_rpos;
                    r_bfirst <= 1'b1;
                    r_ghit   <= 1'b0;
                    r_gup    <= 1'b1;
                    r_state  <= S_G_TEST;
                end

                S_G_TEST: begin
                    if (w_g_inb) begin
                        r_state <= S_B_START;
                    end else begin
                        r_state <= r_gup ? S_G_INIT_DN : S_R_POST;
                    end
                end

                S_G_POST: begin
                    if (!r_bhit && r_ghit) begin
                        r_state <= r_gup ? S_G_INIT_DN : S_R_POST;
                    end else begin
                        if (r_bhit && !r_ghit) begin
                            // first row hit: it becomes the next plane's start row
                            if (!r_gup || (r_g > r_g_here)) begin
                                r_g_here <= r_g;
                                r_rpos   <= r_kp;
                                r_rdist  <= r_kd;
                                r_g_inc  <= r_gx;
                            end
                            r_ghit <= 1'b1;
                        end
                        r_bfirst <= 1'b0;
                        if (r_gup) begin
                            r_g     <= r_g + CW'(1);
                            r_gpos  <= r_gpos + r_gstr;
                            r_kp    <= r_kp + r_gstr;
                            r_gdist <= r_gdist + r_gx;
                            r_kd    <= r_kd + r_gx;
                            r_gx    <= r_gx + r_tstep;
                        end else begin
                            r_g     <= r_g - CW'(1);
                            r_gpos  <= r_gpos - r_gstr;
                            r_kp    <= r_kp - r_gstr;
                            r_gx    <= r_gx - r_tstep;
                            r_gdist <= r_gdist - (r_gx - r_tstep);
                            r_kd    <= r_kd - (r_gx - r_tstep);
                        end
                        r_state <= S_G_TEST;
                    end
                end

                S_G_INIT_DN: begin
                    r_g      <= r_g_here - CW'(1);
                    r_gx     <= r_g_inc - r_tstep;
                    r_kd     <= r_rdist - (r_g_inc - r_tstep);
                    r_gdist  <= r_rdist - (r_g_inc - r_tstep);
                    r_kp     <= r_rpos - r_gstr;
                    r_gpos   <= r_rpos - r_gstr;
                    r_bfirst <= 1'b1;
                    r_gup    <= 1'b0;
                    r_state  <= S_G_TEST;
                end

                // ---- blue runs ----
                S_B_START: begin
                    r_b_here <= w_bh;
                    r_b_inc  <= w_bh_inc;
                    r_b      <= w_bh;
                    r_bx     <= w_bh_inc;
                    r_bd     <= r_gdist;
                    r_p      <= r_gpos;
                    r_bhit   <= 1'b0;
                    r_bph    <= BP_UP_SEEK;
                    r_state  <= S_B_TEST;
                end

                S_B_TEST: begin
                    if (w_b_inb) begin
                        r_state <= S_B_CMP;
                    end else begin
                        r_state <= w_bup ? S_B_INIT_DN : S_G_POST;
                    end
                end

                S_B_CMP: begin
                    if (w_closer && ((r_bph == BP_DN_SEEK)
                                     || ((r_bph == BP_UP_SEEK) && (r_b > r_b_here)))) begin
                        r_b_here <= r_b;
                        r_gpos   <= r_p;
                        r_gdist  <= r_bd;
                        r_b_inc  <= r_bx;
                    end
                    if (w_closer) begin
                        r_bhit <= 1'b1;
                        case (r_bph)
                            BP_UP_SEEK: r_bph <= BP_UP_FILL;
                            BP_DN_SEEK: r_bph <= BP_DN_FILL;
                            default:    r_bph <= r_bph;
                        endcase
                    end
                    if (!w_closer && (r_bph == BP_UP_FILL)) begin
                        r_state <= S_B_INIT_DN;
                    end else if (!w_closer && (r_bph == BP_DN_FILL)) begin
                        r_state <= S_G_POST;
                    end else begin
                        if (w_bup) begin
                            r_b  <= r_b + CW'(1);
                            r_p  <= r_p + ADDR_W'(1);
                            r_bd <= r_bd + r_bx;
                            r_bx <= r_bx + r_tstep;
                        end else begin
                            r_b  <= r_b - CW'(1);
                            r_p  <= r_p - ADDR_W'(1);
                            r_bx <= r_bx - r_tstep;
                            r_bd <= r_bd - (r_bx - r_tstep);
                        end
                        r_state <= S_B_TEST;
                    end
                end

                S_B_INIT_DN: begin
                    r_b     <= r_b_here - CW'(1);
                    r_bx    <= r_b_inc - r_tstep;
                    r_bd    <= r_gdist - (r_b_inc - r_tstep);
                    r_p     <= r_gpos - ADDR_W'(1);
                    r_bph   <= r_bhit ? BP_DN_FILL : BP_DN_SEEK;
                    r_state <= S_B_TEST;
                end

                // ---- lookup ----
                S_LOOK: begin
                    r_state <= S_LOOK_RD;
                end

                S_LOOK_RD: begin
                    r_res_idx <= r_rd_data[IDX_W-1:0];
                    r_res_iv  <= 1'b1;
                    r_state   <= S_DONE;
                end

                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_idx   <= r_res_idx;
                        r_o_iv    <= r_res_iv;
                        if (r_cmd == CMD_ADD) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (r_cmd == CMD_FINISH) begin
                            r_map_valid <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/icb_checker.sv -----
// ----------------------------------------------------------------------------
// icb_checker
// Port-level checks of the inverse colormap builder, bound to the top level.
// ----------------------------------------------------------------------------
module icb_checker
    import icb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic [IDX_W-1:0] i_out_index,
    input logic             i_out_index_valid,
    input logic             i_out_done
);

    // reset starts the clearing pass, so nothing is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("word accepted during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second word taken while one is in work");

    a_done_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_done)
        else $error("result word without done");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_index_valid) |-> (i_out_index == '0))
        else $error("index nonzero on an invalid result");

endmodule

bind inverse_colormap_builder_top icb_checker u_icb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_index       (o_out.palette_index),
    .i_out_index_valid (o_out.index_valid),
    .i_out_done        (o_out.done_res)
);

// ----- verif/icb_test_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icb_test_if
// Result-word type of the test. The testbench uses the design's channel
// interfaces as they stand, one per direction, driven from the test top.
// ----------------------------------------------------------------------------
package icb_test_pkg;
    import icb_pkg::*;

    // one result word as the test expects it
    typedef struct packed {
        logic [IDX_W-1:0] palette_index;
        logic             index_valid;
        logic             done_res;
    } t_map_reply;
endpackage

// ----- verif/inverse_colormap_builder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_colormap_builder_top_test
// Self-checking test of the inverse colormap builder: command words are sent
// with random gaps, a behavioral copy of the cube predicts each result word,
// and the result stream is compared field by field under random back-pressure.
// ----------------------------------------------------------------------------
module inverse_colormap_builder_top_test;
    import icb_pkg::*;
    import icb_test_pkg::*;

    localparam int CUBE_BITS = 6;
    localparam int DEPTH     = 1 << (3 * CUBE_BITS);
    localparam int LIMIT     = 8_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    icb_in_if  u_in_if ();
    icb_out_if u_out_if ();

    inverse_colormap_builder_top #(.MAX_BITS(CUBE_BITS)) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (u_in_if),
        .o_out     (u_out_if)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // ------------------------------------------------------------------
    // behavioral cube
    // ------------------------------------------------------------------
    int unsigned     dist_mem [DEPTH];
    logic [IDX_W-1:0] idx_mem [DEPTH];
    logic [CNT_W-1:0] n_colors;
    logic            map_ok;
    logic [CFG_W-1:0] prec;

    int lim_hi, rstr, gstr, rc, gc, bc, cpos, rpos, gpos, g_here, b_here;
    int unsigned cdist, inc_r, inc_g, inc_b, tstep, rdist, gdist, g_inc, b_inc;
    logic [IDX_W-1:0] cur_idx;

    t_map_reply replies_due[$];
    int n_words, n_adds, n_lookups, n_checked, n_bad;
    bit tx_quiet, rx_quiet;

    function automatic int eff_prec();
        int b;
        b = int'(prec);
        if (b < PREC_MIN) b = PREC_MIN;
        if (b > CUBE_BITS) b = CUBE_BITS;
        return b;
    endfunction

    function automatic bit nearer(int p, int unsigned d);
        return dist_mem[p & (DEPTH - 1)] > d;
    endfunction

    function automatic void take(int p, int unsigned d);
        dist_mem[p & (DEPTH - 1)] = d & 32'h3FFFF;
        idx_mem[p & (DEPTH - 1)]  = cur_idx;
    endfunction

    function automatic void clear_cube();
        for (int i = 0; i < DEPTH; i++) begin
            dist_mem[i] = 32'h3FFFF;
            idx_mem[i]  = '0;
        end
        n_colors = '0;
        map_ok   = 1'b0;
    endfunction

    function automatic bit blue_run(bit restart);
        bit hit;
        int b, p;
        int unsigned bd, bx;
        hit = 1'b0;
        if (restart) begin
            b_here = bc;
            b_inc  = inc_b;
        end
        b = b_here; bd = gdist; bx = b_inc; p = gpos;
        while (b <= lim_hi) begin
            if (nearer(p, bd)) begin
                if (b > b_here) begin
                    b_here = b; gpos = p; gdist = bd; b_inc = bx;
                end
                hit = 1'b1;
                break;
            end
            b++; p++; bd += bx; bx += tstep;
        end
        while (b <= lim_hi) begin
            if (!nearer(p, bd)) break;
            take(p, bd);
            b++; p++; bd += bx; bx += tstep;
        end
        b = b_here - 1; bx = b_inc - tstep; bd = gdist - bx; p = gpos - 1;
        if (!hit) begin
            while (b >= 0) begin
                if (nearer(p, bd)) begin
                    b_here = b; gpos = p; gdist = bd; b_inc = bx;
                    hit = 1'b1;
                    break;
                end
                b--; p--; bx -= tstep; bd -= bx;
            end
        end
        while (b >= 0) begin
            if (!nearer(p, bd)) break;
            take(p, bd);
            b--; p--; bx -= tstep; bd -= bx;
        end
        return hit;
    endfunction

    function automatic bit green_run(bit restart);
        bit hit, first;
        int g, kp;
        int unsigned kd, gx;
        hit = 1'b0;
        if (restart) begin
            g_here = gc;
            g_inc  = inc_g;
        end
        g = g_here; gdist = rdist; kd = rdist; gx = g_inc;
        gpos = rpos; kp = rpos; first = 1'b1;
        while (g <= lim_hi) begin
            if (blue_run(first)) begin
                if (!hit) begin
                    if (g > g_here) begin
                        g_here = g; rpos = kp; rdist = kd; g_inc = gx;
                    end
                    hit = 1'b1;
                end
            end else if (hit) begin
                break;
            end
            g++; gpos += gstr; kp += gstr; gdist += gx; kd += gx; gx += tstep;
            first = 1'b0;
        end
        g = g_here - 1; gx = g_inc - tstep; gdist = rdist - gx; kd = gdist;
        gpos = rpos - gstr; kp = gpos; first = 1'b1;
        while (g >= 0) begin
            if (blue_run(first)) begin
                if (!hit) begin
                    g_here = g; rpos = kp; rdist = kd; g_inc = gx;
                    hit = 1'b1;
                end
            end else if (hit) begin
                break;
            end
            g--; gpos -= gstr; kp -= gstr; gx -= tstep; gdist -= gx; kd -= gx;
            first = 1'b0;
        end
        return hit;
    endfunction

    function automatic void red_run();
        bit hit, first;
        int r;
        int unsigned rx;
        hit = 1'b0;
        r = rc; rdist = cdist; rx = inc_r; rpos = cpos; first = 1'b1;
        while (r <= lim_hi) begin
            if (green_run(first)) hit = 1'b1;
            else if (hit) break;
            r++; rpos += rstr; rdist += rx; rx += tstep; first = 1'b0;
        end
        r = rc - 1; rx = inc_r - tstep; rdist = cdist - rx; rpos = cpos - rstr;
        first = 1'b1;
        while (r >= 0) begin
            if (green_run(first)) hit = 1'b1;
            else if (hit) break;
            r--; rpos -= rstr; rx -= tstep; rdist -= rx; first = 1'b0;
        end
    endfunction

    function automatic void paint_color(int cr, int cg, int cb);
        int bits, sh, dr, dg, db, ir, ig, ib, x, xsq, r6, g6, b6;
        bits   = eff_prec();
        sh     = 8 - bits;
        lim_hi = (1 << bits) - 1;
        gstr   = 1 << bits;
        rstr   = 1 << (2 * bits);
        cur_idx = n_colors[IDX_W-1:0];
        if (bits == PREC_SPECIAL) begin
            // 5-bit mode: 6-bit values against centers 2c+1, step 8
            r6 = cr >> 2; g6 = cg >> 2; b6 = cb >> 2;
            rc = cr >> 3; gc = cg >> 3; bc = cb >> 3;
            dr = r6 - (2 * rc + 1); dg = g6 - (2 * gc + 1); db = b6 - (2 * bc + 1);
            ir = 4 - 4 * r6 + 8 * rc;
            ig = 4 - 4 * g6 + 8 * gc;
            ib = 4 - 4 * b6 + 8 * bc;
            tstep = 8;
        end else begin
            x   = 1 << sh;
            xsq = 1 << (2 * sh);
            rc = cr >> sh; gc = cg >> sh; bc = cb >> sh;
            dr = cr - (rc * x + x / 2);
            dg = cg - (gc * x + x / 2);
            db = cb - (bc * x + x / 2);
            ir = 2 * ((rc + 1) * xsq - cr * x);
            ig = 2 * ((gc + 1) * xsq - cg * x);
            ib = 2 * ((bc + 1) * xsq - cb * x);
            tstep = 2 * xsq;
        end
        cdist = dr * dr + dg * dg + db * db;
        inc_r = ir; inc_g = ig; inc_b = ib;
        cpos = rc * rstr + gc * gstr + bc;
        red_run();
        n_colors = n_colors + 1'b1;
    endfunction

    function automatic t_map_reply map_reply(t_cmd cmd, int cr, int cg, int cb);
        t_map_reply rep;
        int bits, sh, a;
        rep = '{palette_index: '0, index_valid: 1'b0, done_res: 1'b1};
        case (cmd)
            CMD_START:  clear_cube();
            CMD_ADD:    paint_color(cr, cg, cb);
            CMD_FINISH: map_ok = 1'b1;
            CMD_LOOKUP: begin
                if (map_ok) begin
                    bits = eff_prec();
                    sh   = 8 - bits;
                    a = ((cr >> sh) << (2 * bits)) | ((cg >> sh) << bits) | (cb >> sh);
                    rep.palette_index = idx_mem[a & (DEPTH - 1)];
                    rep.index_valid   = 1'b1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_word(t_cmd cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!tx_quiet && $urandom_range(99) < 30) begin
            u_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        u_in_if.valid   <= 1'b1;
        u_in_if.command <= cmd;
        u_in_if.red     <= r;
        u_in_if.green   <= g;
        u_in_if.blue    <= b;
        do @(posedge i_clk); while (!u_in_if.ready);
        replies_due.push_back(map_reply(cmd, int'(r), int'(g), int'(b)));
        n_words++;
        if (cmd == CMD_ADD) n_adds++;
        if (cmd == CMD_LOOKUP) n_lookups++;
    endtask

    task automatic drain();
        u_in_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_prec(logic [CFG_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        prec = v;
    endtask

    task automatic lookup_corners();
        send_word(CMD_LOOKUP, 8'h00, 8'h00, 8'h00);
        send_word(CMD_LOOKUP, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_LOOKUP, 8'hFF, 8'h00, 8'h80);
        send_word(CMD_LOOKUP, 8'h55, 8'hAA, 8'h33);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_unfinished_and_empty();
        send_word(CMD_LOOKUP, 8'h12, 8'h34, 8'h56);   // before finish: invalid
        send_word(CMD_FINISH, 8'h00, 8'h00, 8'h00);   // empty map becomes valid
        lookup_corners();
    endtask

    task automatic test_coarse_palette();
        write_prec(3'd4);
        send_word(CMD_START, 8'h00, 8'h00, 8'h00);
        send_word(CMD_LOOKUP, 8'h80, 8'h80, 8'h80);
        send_word(CMD_ADD, 8'h00, 8'h00, 8'h00);
        send_word(CMD_ADD, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_ADD, 8'hFF, 8'hFF, 8'hFF);      // tie: earlier index kept
        send_word(CMD_ADD, 8'hFF, 8'h00, 8'h80);
        send_word(CMD_FINISH, 8'h00, 8'h00, 8'h00);
        send_word(CMD_ADD, 8'h00, 8'hFF, 8'h00);      // add after finish
        lookup_corners();
    endtask

    task automatic test_precision_modes();
        write_prec(3'd3);                             // below range, acts as 4
        send_word(CMD_ADD, 8'h40, 8'hC0, 8'h20);
        lookup_corners();
        write_prec(3'd5);                             // experimental 5-bit math
        send_word(CMD_ADD, 8'h87, 8'h3C, 8'hE1);
        send_word(CMD_ADD, 8'h07, 8'hF8, 8'h7F);
        lookup_corners();
        write_prec(3'd6);
        lookup_corners();
        write_prec(3'd7);                             // above range, acts as 6
        lookup_corners();
        write_prec(3'd0);
        lookup_corners();
    endtask

    task automatic test_random_traffic();
        int pick;
        // 6-bit adds sweep the whole cube, so random adds stay at 4 bits
        write_prec(3'd4);
        for (int i = 0; i < 95; i++) begin
            tx_quiet = (i >= 30 && i < 70);
            if (i == 75) drain();
            pick = $urandom_range(99);
            if (pick < 55)
                send_word(CMD_ADD, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 92)
                send_word(CMD_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_word(CMD_FINISH, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        tx_quiet = 1'b0;
        write_prec(3'd5);
        for (int i = 0; i < 4; i++) begin
            send_word(CMD_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // result checker, back-pressure and watchdog
    // ------------------------------------------------------------------
    int cycles;

    always @(posedge i_clk) begin
        t_map_reply want, got;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            u_out_if.ready <= rx_quiet || ($urandom_range(99) >= 30);
            if (u_out_if.valid && u_out_if.ready) begin
                got = '{u_out_if.palette_index, u_out_if.index_valid, u_out_if.done_res};
                if (replies_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected word %p", got);
                end else begin
                    want = replies_due.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10) $display("word %0d: expected %p, got %p",
                                                  n_checked, want, got);
                    end
                end
            end
        end
    end

    initial begin
        cycles          = 0;
        n_words         = 0;
        n_adds          = 0;
        n_lookups       = 0;
        n_checked       = 0;
        n_bad           = 0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        u_in_if.valid   = 1'b0;
        u_in_if.command = CMD_START;
        u_in_if.red     = '0;
        u_in_if.green   = '0;
        u_in_if.blue    = '0;
        u_out_if.ready  = 1'b0;
        prec            = PREC_RESET;
        clear_cube();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unfinished_and_empty();
        test_coarse_palette();
        test_precision_modes();
        rx_quiet = 1'b1;
        test_random_traffic();
        rx_quiet = 1'b0;

        u_in_if.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("%0d words sent (%0d palette adds, %0d lookups), %0d results checked",
                 n_words, n_adds, n_lookups, n_checked);
        $display("precision settings 0, 3..7 exercised, %0d mismatches", n_bad);
        if (n_bad == 0 && replies_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- inverse_colormap_builder_top.f -----
hw/rtl/icb_pkg.sv
hw/rtl/icb_if.sv
hw/rtl/inverse_colormap_builder_top.sv
hw/rtl/icb_checker.sv
verif/icb_test_if.sv
verif/inverse_colormap_builder_top_test.sv
